// File: sv/csd_pkg.sv
// Package for the concentric square-to-disk unit: types, constants, tables.
package csd_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 16;

    localparam int IN_W    = 16;
    localparam int OUT_W   = IN_W + 1;
    localparam int COORD_W = IN_W + 2;
    localparam int R_W     = IN_W + 1;
    localparam int QUO_W   = FRAC_BITS + 1;
    localparam int REM_W   = R_W + 1;
    localparam int ANG_W   = FRAC_BITS + 3;
    localparam int XY_W    = FRAC_BITS + 4;
    localparam int PI_W    = 31;
    localparam int PROD_W  = QUO_W + 1 + PI_W;
    localparam int MUL_W   = R_W + 1 + XY_W;
    localparam int V_W     = MUL_W + 1;
    localparam int Q_SHIFT = 30 - FRAC_BITS;

    localparam int DIV_STEPS = QUO_W;
    localparam int P_MUL     = DIV_STEPS + 1;
    localparam int P_Z       = DIV_STEPS + 2;
    localparam int P_RM      = P_Z + CORDIC_STEPS + 1;
    localparam int P_OUT     = P_RM + 1;
    localparam int NSTG      = P_OUT + 1;

    localparam logic [PI_W-1:0] PI4_Q30  = 31'd843314857;
    localparam logic [31:0]     GAIN_Q30 = 32'd652032874;

    localparam logic [30:0] ATAN_Q30 [31] = '{
        31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159, 31'd67021687,
        31'd33543516, 31'd16775851, 31'd8388437, 31'd4194283, 31'd2097149,
        31'd1048576, 31'd524288, 31'd262144, 31'd131072, 31'd65536, 31'd32768,
        31'd16384, 31'd8192, 31'd4096, 31'd2048, 31'd1024, 31'd512, 31'd256,
        31'd128, 31'd64, 31'd32, 31'd16, 31'd8, 31'd4, 31'd2, 31'd1
    };

    typedef enum logic [1:0] {
        SEC_RIGHT = 2'd0,
        SEC_TOP   = 2'd1,
        SEC_LEFT  = 2'd2,
        SEC_BOT   = 2'd3
    } sector_t;

    typedef struct packed {
        logic [IN_W-1:0] in_x;
        logic [IN_W-1:0] in_y;
        logic            in_last;
    } sample_t;

    typedef struct packed {
        logic [OUT_W-1:0] disk_x;
        logic [OUT_W-1:0] disk_y;
        logic             out_last;
    } disk_t;

    typedef struct packed {
        logic           last;
        sector_t        sector;
        logic [R_W-1:0] r;
    } meta_t;

    // Round a Q.30 constant to FRAC_BITS fraction bits, half up.
    function automatic logic [31:0] q30_to_frac(input logic [31:0] v);
        logic [32:0] t;
        begin
            if (Q_SHIFT == 0)
            begin
                t = {1'b0, v};
            end
            else
            begin
                t = ({1'b0, v} + (33'd1 << (Q_SHIFT - 1))) >> Q_SHIFT;
            end
            return t[31:0];
        end
    endfunction

    function automatic logic [ANG_W-1:0] atan_frac(input int i);
        logic [31:0] t;
        begin
            t = q30_to_frac({1'b0, ATAN_Q30[(i > 30) ? 30 : i]});
            return t[ANG_W-1:0];
        end
    endfunction

    localparam logic [31:0]     GAIN_F = q30_to_frac(GAIN_Q30);
    localparam logic [XY_W-1:0] GAIN   = GAIN_F[XY_W-1:0];

endpackage

// File: sv/concentric_square_to_disk_unit.sv
// Concentric square-to-disk mapping pipeline: divider, angle scale, CORDIC, remap.
// Takes one sample per cycle while the disk side does not stall and returns one disk point
// per sample, in order, through csd_pkg::NSTG (38) register stages: one input register, 17
// restoring-divider stages (one quotient bit each), a pi/4 multiply, the angle round, 16
// CORDIC rotation stages, the radius multiply and the output register. A stall on the disk
// side freezes the whole pipeline and is reflected on sample_stall in the same cycle; an
// empty output register never holds back the pipe.
module concentric_square_to_disk_unit
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_valid,
    output logic             sample_stall,
    input  csd_pkg::sample_t sample,
    output logic             disk_valid,
    input  logic             disk_stall,
    output csd_pkg::disk_t   disk
);

    logic adv;
    logic vld_reg [csd_pkg::NSTG];
    csd_pkg::meta_t meta_reg  [csd_pkg::P_RM + 1];
    csd_pkg::meta_t meta_next [csd_pkg::P_RM + 1];

    logic [csd_pkg::REM_W-1:0] rem_reg  [csd_pkg::DIV_STEPS + 1];
    logic [csd_pkg::REM_W-1:0] rem_next [csd_pkg::DIV_STEPS + 1];
    logic [csd_pkg::QUO_W-1:0] quo_reg  [csd_pkg::DIV_STEPS + 1];
    logic [csd_pkg::QUO_W-1:0] quo_next [csd_pkg::DIV_STEPS + 1];
    logic [csd_pkg::R_W-1:0]   den_reg  [csd_pkg::DIV_STEPS + 1];
    logic [csd_pkg::R_W-1:0]   den_next [csd_pkg::DIV_STEPS + 1];
    logic                      neg_reg  [csd_pkg::DIV_STEPS + 1];
    logic                      neg_next [csd_pkg::DIV_STEPS + 1];

    logic signed [csd_pkg::PROD_W-1:0] prod_reg, prod_next;

    logic signed [csd_pkg::XY_W-1:0]  cx_reg  [csd_pkg::CORDIC_STEPS + 1];
    logic signed [csd_pkg::XY_W-1:0]  cx_next [csd_pkg::CORDIC_STEPS + 1];
    logic signed [csd_pkg::XY_W-1:0]  cy_reg  [csd_pkg::CORDIC_STEPS + 1];
    logic signed [csd_pkg::XY_W-1:0]  cy_next [csd_pkg::CORDIC_STEPS + 1];
    logic signed [csd_pkg::ANG_W-1:0] cz_reg  [csd_pkg::CORDIC_STEPS + 1];
    logic signed [csd_pkg::ANG_W-1:0] cz_next [csd_pkg::CORDIC_STEPS + 1];

    logic signed [csd_pkg::MUL_W-1:0] mx_reg, mx_next, my_reg, my_next;
    csd_pkg::disk_t out_reg, out_next;

    // input stage signals
    logic signed [csd_pkg::COORD_W-1:0] sx, sy, rs, ns;
    csd_pkg::sector_t sec;
    logic neg0;
    logic [csd_pkg::R_W-1:0] r0, nabs;

    assign adv          = !vld_reg[csd_pkg::P_OUT] || !disk_stall;
    assign sample_stall = !adv;
    assign disk_valid   = vld_reg[csd_pkg::P_OUT];
    assign disk         = out_reg;

    function automatic logic [csd_pkg::OUT_W-1:0] remap(
        input logic signed [csd_pkg::MUL_W-1:0] p);
        logic signed [csd_pkg::V_W-1:0] v;
        logic signed [csd_pkg::V_W-1:0] o;
        begin
            v = csd_pkg::V_W'(p) + (csd_pkg::V_W'(1) << (16 + csd_pkg::FRAC_BITS));
            o = (v + (csd_pkg::V_W'(1) << csd_pkg::FRAC_BITS)) >>> (csd_pkg::FRAC_BITS + 1);
            if (v < 0)
            begin
                return '0;
            end
            else if (o > csd_pkg::V_W'(1 << csd_pkg::IN_W))
            begin
                return csd_pkg::OUT_W'(1 << csd_pkg::IN_W);
            end
            else
            begin
                return o[csd_pkg::OUT_W-1:0];
            end
        end
    endfunction

    // sector choice and divider operands
    always_comb
    begin
        sx = $signed({1'b0, sample.in_x, 1'b0}) - $signed(csd_pkg::COORD_W'(1 << csd_pkg::IN_W));
        sy = $signed({1'b0, sample.in_y, 1'b0}) - $signed(csd_pkg::COORD_W'(1 << csd_pkg::IN_W));
        if (sx > -sy)
        begin
            if (sx > sy)
            begin
                sec = csd_pkg::SEC_RIGHT; rs = sx;  ns = sy; neg0 = sy < 0;
            end
            else
            begin
                sec = csd_pkg::SEC_TOP;   rs = sy;  ns = sx; neg0 = sx > 0;
            end
        end
        else
        begin
            if (sx < sy)
            begin
                sec = csd_pkg::SEC_LEFT;  rs = -sx; ns = sy; neg0 = sy > 0;
            end
            else
            begin
                sec = csd_pkg::SEC_BOT;   rs = -sy; ns = sx; neg0 = sx < 0;
            end
        end
        r0   = rs[csd_pkg::R_W-1:0];
        nabs = (ns < 0) ? csd_pkg::R_W'(-ns) : ns[csd_pkg::R_W-1:0];
    end

    always_comb
    begin
        // input register; the origin divides zero by one
        meta_next[0].last   = sample.in_last;
        meta_next[0].sector = sec;
        meta_next[0].r      = r0;
        den_next[0] = (r0 == '0) ? csd_pkg::R_W'(1) : r0;
        rem_next[0] = (r0 == '0) ? '0 : {1'b0, nabs};
        quo_next[0] = '0;
        neg_next[0] = neg0;

        for (int d = 0; d < csd_pkg::DIV_STEPS; d++)
        begin
            logic [csd_pkg::REM_W-1:0] trial;
            trial = (d == 0) ? rem_reg[d] : {rem_reg[d][csd_pkg::REM_W-2:0], 1'b0};
            meta_next[d+1] = meta_reg[d];
            den_next[d+1]  = den_reg[d];
            neg_next[d+1]  = neg_reg[d];
            if (trial >= {1'b0, den_reg[d]})
            begin
                rem_next[d+1] = trial - {1'b0, den_reg[d]};
                quo_next[d+1] = {quo_reg[d][csd_pkg::QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[d+1] = trial;
                quo_next[d+1] = {quo_reg[d][csd_pkg::QUO_W-2:0], 1'b0};
            end
        end

        // angle = q * pi/4
        begin
            logic signed [csd_pkg::QUO_W:0] qs;
            qs = neg_reg[csd_pkg::DIV_STEPS]
                ? -$signed({1'b0, quo_reg[csd_pkg::DIV_STEPS]})
                :  $signed({1'b0, quo_reg[csd_pkg::DIV_STEPS]});
            prod_next = csd_pkg::PROD_W'(qs) * $signed({1'b0, csd_pkg::PI4_Q30});
            meta_next[csd_pkg::P_MUL] = meta_reg[csd_pkg::DIV_STEPS];
        end

        // round the angle to FRAC_BITS and seed the rotation
        begin
            logic signed [csd_pkg::PROD_W-1:0] zr;
            zr = (prod_reg + (csd_pkg::PROD_W'(1) << 29)) >>> 30;
            cz_next[0] = zr[csd_pkg::ANG_W-1:0];
            cx_next[0] = csd_pkg::GAIN;
            cy_next[0] = '0;
            meta_next[csd_pkg::P_Z] = meta_reg[csd_pkg::P_MUL];
        end

        for (int i = 0; i < csd_pkg::CORDIC_STEPS; i++)
        begin
            logic signed [csd_pkg::XY_W-1:0] xs, ys;
            xs = cx_reg[i] >>> i;
            ys = cy_reg[i] >>> i;
            meta_next[csd_pkg::P_Z+i+1] = meta_reg[csd_pkg::P_Z+i];
            if (!cz_reg[i][csd_pkg::ANG_W-1])
            begin
                cx_next[i+1] = cx_reg[i] - ys;
                cy_next[i+1] = cy_reg[i] + xs;
                cz_next[i+1] = cz_reg[i] - $signed(csd_pkg::atan_frac(i));
            end
            else
            begin
                cx_next[i+1] = cx_reg[i] + ys;
                cy_next[i+1] = cy_reg[i] - xs;
                cz_next[i+1] = cz_reg[i] + $signed(csd_pkg::atan_frac(i));
            end
        end

        // turn to the sector center and scale by the radius
        begin
            logic signed [csd_pkg::XY_W-1:0] c, s, rc, rsn;
            logic signed [csd_pkg::R_W:0]    rr;
            csd_pkg::meta_t m;
            m  = meta_reg[csd_pkg::P_RM - 1];
            c  = cx_reg[csd_pkg::CORDIC_STEPS];
            s  = cy_reg[csd_pkg::CORDIC_STEPS];
            rr = $signed({1'b0, m.r});
            unique case (m.sector)
                csd_pkg::SEC_RIGHT: begin rc = c;  rsn = s;  end
                csd_pkg::SEC_TOP:   begin rc = -s; rsn = c;  end
                csd_pkg::SEC_LEFT:  begin rc = -c; rsn = -s; end
                default:            begin rc = s;  rsn = -c; end
            endcase
            mx_next = csd_pkg::MUL_W'(rr) * csd_pkg::MUL_W'(rc);
            my_next = csd_pkg::MUL_W'(rr) * csd_pkg::MUL_W'(rsn);
            meta_next[csd_pkg::P_RM] = m;
        end

        out_next.disk_x   = remap(mx_reg);
        out_next.disk_y   = remap(my_reg);
        out_next.out_last = meta_reg[csd_pkg::P_RM].last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < csd_pkg::NSTG; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= sample_valid;
            for (int k = 1; k < csd_pkg::NSTG; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // advance the payload together with the valid bits
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k <= csd_pkg::P_RM; k++)
            begin
                meta_reg[k] <= meta_next[k];
            end
            for (int d = 0; d <= csd_pkg::DIV_STEPS; d++)
            begin
                rem_reg[d] <= rem_next[d];
                quo_reg[d] <= quo_next[d];
                den_reg[d] <= den_next[d];
                neg_reg[d] <= neg_next[d];
            end
            prod_reg <= prod_next;
            for (int i = 0; i <= csd_pkg::CORDIC_STEPS; i++)
            begin
                cx_reg[i] <= cx_next[i];
                cy_reg[i] <= cy_next[i];
                cz_reg[i] <= cz_next[i];
            end
            mx_reg  <= mx_next;
            my_reg  <= my_next;
            out_reg <= out_next;
        end
    end

endmodule

// File: sv/csd_checker.sv
// Port checker for the concentric square-to-disk unit, bound to the top level.
module csd_checker
(
    input logic             clk,
    input logic             rst_n,
    input logic             sample_stall,
    input logic             disk_valid,
    input logic             disk_stall,
    input csd_pkg::disk_t   disk
);

    // hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        disk_valid && disk_stall |=> disk_valid && $stable(disk))
        else $error("stalled disk transfer changed");

    // results stay on the unit square
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        disk_valid |-> disk.disk_x <= 17'd65536 && disk.disk_y <= 17'd65536)
        else $error("disk coordinate above one");

    // the input side stalls only behind a stalled output
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> disk_valid && disk_stall)
        else $error("sample stalled without backpressure");

    // a drained output frees the input side
    a_free: assert property (@(posedge clk) disable iff (!rst_n)
        !disk_valid |-> !sample_stall)
        else $error("sample stalled with empty output");

endmodule

bind concentric_square_to_disk_unit csd_checker u_csd_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_stall (sample_stall),
    .disk_valid   (disk_valid),
    .disk_stall   (disk_stall),
    .disk         (disk)
);

// File: sim/tb_concentric_square_to_disk_unit.sv
// Testbench for the concentric square-to-disk unit: random and corner samples against a predictor.
`timescale 1ns / 100ps

module tb_concentric_square_to_disk_unit;

    localparam int N_RANDOM = 750;
    localparam int CALM_TAIL = 120;

    class disk_scoreboard;
        csd_pkg::disk_t pending[$];
        int             errors;

        function new();
            errors = 0;
        endfunction

        static function longint shr_floor(longint v, int s);
            return v >>> s;
        endfunction

        static function longint frac_of_q30(longint v);
            if (30 - csd_pkg::FRAC_BITS == 0)
                return v;
            return (v + (longint'(1) << (29 - csd_pkg::FRAC_BITS))) >>> (30 - csd_pkg::FRAC_BITS);
        endfunction

        static function longint quotient(longint num, longint den);
            longint n;
            longint d;
            longint q;
            n = (num < 0) ? -num : num;
            d = (den < 0) ? -den : den;
            q = (n << csd_pkg::FRAC_BITS) / d;
            return ((num < 0) != (den < 0)) ? -q : q;
        endfunction

        static function logic [csd_pkg::OUT_W-1:0] to_unit(longint r, longint c);
            longint v;
            longint o;
            v = r * c + (longint'(1) << (16 + csd_pkg::FRAC_BITS));
            if (v < 0)
                return '0;
            o = (v + (longint'(1) << csd_pkg::FRAC_BITS)) >>> (csd_pkg::FRAC_BITS + 1);
            if (o > 65536)
                o = 65536;
            return o[csd_pkg::OUT_W-1:0];
        endfunction

        static function csd_pkg::disk_t map_point(csd_pkg::sample_t s);
            longint           sx;
            longint           sy;
            longint           r;
            longint           q;
            longint           z;
            longint           x;
            longint           y;
            longint           a;
            longint           xs;
            longint           ys;
            longint           rc;
            longint           rs;
            csd_pkg::sector_t sec;
            csd_pkg::disk_t   d;
            sx = 2 * longint'(s.in_x) - 65536;
            sy = 2 * longint'(s.in_y) - 65536;
            if (sx > -sy)
            begin
                if (sx > sy)
                begin
                    sec = csd_pkg::SEC_RIGHT; r = sx; q = quotient(sy, sx);
                end
                else
                begin
                    sec = csd_pkg::SEC_TOP; r = sy; q = -quotient(sx, sy);
                end
            end
            else if (sx < sy)
            begin
                sec = csd_pkg::SEC_LEFT; r = -sx; q = quotient(sy, sx);
            end
            else
            begin
                sec = csd_pkg::SEC_BOT; r = -sy;
                q = (sy != 0) ? -quotient(sx, sy) : 0;
            end
            z = shr_floor(q * 843314857 + (longint'(1) << 29), 30);
            x = frac_of_q30(652032874);
            y = 0;
            for (int i = 0; i < csd_pkg::CORDIC_STEPS; i++)
            begin
                a = frac_of_q30(longint'(csd_pkg::ATAN_Q30[(i > 30) ? 30 : i]));
                xs = shr_floor(x, i);
                ys = shr_floor(y, i);
                if (z >= 0)
                begin
                    x -= ys; y += xs; z -= a;
                end
                else
                begin
                    x += ys; y -= xs; z += a;
                end
            end
            case (sec)
                csd_pkg::SEC_RIGHT: begin rc = x;  rs = y;  end
                csd_pkg::SEC_TOP:   begin rc = -y; rs = x;  end
                csd_pkg::SEC_LEFT:  begin rc = -x; rs = -y; end
                default:            begin rc = y;  rs = -x; end
            endcase
            d.disk_x = to_unit(r, rc);
            d.disk_y = to_unit(r, rs);
            d.out_last = s.in_last;
            return d;
        endfunction

        function void note_sample(csd_pkg::sample_t s);
            pending.insert(pending.size(), map_point(s));
        endfunction

        function void check_disk(csd_pkg::disk_t got);
            csd_pkg::disk_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected disk point %h", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.disk_x !== want.disk_x)
            begin
                $error("disk_x expected %0d got %0d", want.disk_x, got.disk_x);
                errors++;
            end
            if (got.disk_y !== want.disk_y)
            begin
                $error("disk_y expected %0d got %0d", want.disk_y, got.disk_y);
                errors++;
            end
            if (got.out_last !== want.out_last)
            begin
                $error("out_last expected %0d got %0d", want.out_last, got.out_last);
                errors++;
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             sample_valid;
    logic             sample_stall;
    csd_pkg::sample_t sample;
    logic             disk_valid;
    logic             disk_stall;
    csd_pkg::disk_t   disk;
    bit               calm;

    disk_scoreboard board;

    concentric_square_to_disk_unit uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .disk_valid   (disk_valid),
        .disk_stall   (disk_stall),
        .disk         (disk)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hold one sample until transferred; optionally idle first.
    task automatic send_sample(input logic [15:0] x, input logic [15:0] y, input logic l);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            sample_valid <= 1'b0;
            gap = int'($urandom_range(1, 4));
            repeat (gap) @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample <= '{in_x: x, in_y: y, in_last: l};
        do
            @(posedge clk);
        while (sample_stall);
        board.note_sample('{in_x: x, in_y: y, in_last: l});
        @(negedge clk);
    endtask

    task automatic send_random;
        logic [15:0] x;
        logic [15:0] y;
        case ($urandom_range(0, 5))
            0: begin x = 16'($urandom); y = x; end
            1: begin x = 16'($urandom); y = 16'hFFFF - x + 16'($urandom_range(0, 2)) - 16'd1; end
            2: begin x = 16'h8000 + 16'($urandom_range(0, 6)) - 16'd3; y = 16'($urandom); end
            default: begin x = 16'($urandom); y = 16'($urandom); end
        endcase
        send_sample(x, y, 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        logic [15:0] corner [6];
        board = new();
        calm = 1'b0;
        rst_n = 1'b0;
        sample_valid = 1'b0;
        sample = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        corner = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'h8001, 16'hFFFF};
        foreach (corner[i])
            foreach (corner[j])
                if ((i + j) % 2 == 0 || i == j)
                    send_sample(corner[i], corner[j], (i == 5));
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == N_RANDOM - CALM_TAIL)
                calm = 1'b1;
            send_random();
        end
        sample_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (csd_pkg::NSTG + 10) @(negedge clk);
        if (board.errors == 0)
            $display("tb_concentric_square_to_disk_unit: clean");
        else
            $display("tb_concentric_square_to_disk_unit: errors");
        $finish;
    end

    // Receiver stall bursts.
    initial
    begin
        int burst;
        disk_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 6) == 0)
            begin
                burst = int'($urandom_range(1, 4));
                disk_stall <= 1'b1;
                repeat (burst) @(negedge clk);
                disk_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && disk_valid && !disk_stall)
            board.check_disk(disk);
    end

    initial
    begin
        #2000000;
        $display("tb_concentric_square_to_disk_unit: errors");
        $finish;
    end

endmodule

// File: filelist.f
sv/csd_pkg.sv
sv/concentric_square_to_disk_unit.sv
sv/csd_checker.sv
sim/tb_concentric_square_to_disk_unit.sv
